[rtl/ple_pkg.sv]
// Package for the positional list engine.
// Holds the item structs, status and request codes, controller states and the
// command and status groups between controller and datapath. No dependencies.
package ple_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam int POS_W       = 5;
	localparam int DATA_W      = 8;
	localparam int STAT_W      = 2;
	localparam int CNT_OUT_W   = 5;

	// request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

	typedef struct packed {
		logic              req_type;
		logic [POS_W-1:0]  position;
		logic [DATA_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [DATA_W-1:0]    data_out;
		logic [CNT_OUT_W-1:0] entry_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_ROUTE,
		S_TAKE_RD,
		S_TAKE_CAP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_FINISH
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic eval;
		logic take_rd;
		logic take_cap;
		logic shift_rd;
		logic shift_wr;
		logic finish;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic failed;
		logic is_remove;
		logic shift_more;
		logic out_busy;
	} dp_stat_t;

endpackage

[rtl/ple_ctrl.sv]
// Controller state machine of the positional list engine.
// Sequences check, removed-byte read, entry shifting and result load.
// Depends on ple_pkg.
module ple_ctrl import ple_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_ROUTE;
			end
			S_ROUTE: begin
				if (stat.failed) begin
					state_d = S_FINISH;
				end else if (stat.is_remove) begin
					state_d = S_TAKE_RD;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_TAKE_RD: begin
				cmd.take_rd = 1'b1;
				state_d     = S_TAKE_CAP;
			end
			S_TAKE_CAP: begin
				cmd.take_cap = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			// one entry moves per read/write pair
			S_SHIFT_RD: begin
				if (stat.shift_more) begin
					cmd.shift_rd = 1'b1;
					state_d      = S_SHIFT_WR;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			// commit and load the result once the output register is free
			S_FINISH: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[rtl/ple_dpath.sv]
// Datapath of the positional list engine: entry memory, entry count,
// request and shift pointer registers, and the output result register.
// Depends on ple_pkg.
module ple_dpath import ple_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output rsp_t     rsp,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [DATA_W-1:0] mem [DEPTH];

	req_t              req_q;
	logic [CW-1:0]     count_q;
	logic [STAT_W-1:0] status_q;
	logic [AW-1:0]     slot_q;
	logic [AW-1:0]     dst_q;
	logic [DATA_W-1:0] taken_q;
	logic [DATA_W-1:0] rdata_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic [EW-1:0]     pos_e;
	logic [EW-1:0]     cnt_e;
	logic [EW-1:0]     slot_e;
	logic              bad_pos;
	logic              is_ins;
	logic              ok;
	logic [STAT_W-1:0] status_d;
	logic [AW-1:0]     raddr;
	logic              rd_en;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [CW-1:0]     count_d;

	// request check
	always_comb begin
		pos_e   = EW'(req_q.position);
		cnt_e   = EW'(count_q);
		bad_pos = (pos_e == '0) || (pos_e > cnt_e + EW'(1));
		is_ins  = (req_q.req_type == REQ_INSERT);
		if (is_ins) begin
			if (bad_pos) begin
				status_d = STAT_BAD_POS;
			end else if (count_q == CW'(DEPTH)) begin
				status_d = STAT_FULL;
			end else begin
				status_d = STAT_OK;
			end
			slot_e = pos_e - EW'(1);
		end else begin
			if (count_q == '0) begin
				status_d = STAT_EMPTY;
			end else if (bad_pos) begin
				status_d = STAT_BAD_POS;
			end else begin
				status_d = STAT_OK;
			end
			// positions 1 and 2 both take the first entry
			slot_e = (pos_e <= EW'(2)) ? '0 : pos_e - EW'(2);
		end
	end

	assign ok = (status_q == STAT_OK);

	// status to controller
	always_comb begin
		stat.failed    = !ok;
		stat.is_remove = !is_ins;
		stat.out_busy  = rsp_valid_q && rsp_stall;
		if (is_ins) begin
			stat.shift_more = (dst_q > slot_q);
		end else begin
			stat.shift_more = ((CW+1)'(dst_q) + (CW+1)'(1)) < (CW+1)'(count_q);
		end
	end

	// memory port selection
	always_comb begin
		rd_en = cmd.take_rd || cmd.shift_rd;
		if (cmd.take_rd) begin
			raddr = slot_q;
		end else if (is_ins) begin
			raddr = dst_q - AW'(1);
		end else begin
			raddr = dst_q + AW'(1);
		end
		we    = cmd.shift_wr || (cmd.finish && ok && is_ins);
		waddr = cmd.shift_wr ? dst_q : slot_q;
		wdata = cmd.shift_wr ? rdata_q : req_q.data_in;
	end

	// count after this item
	always_comb begin
		count_d = count_q;
		if (ok) begin
			count_d = is_ins ? count_q + CW'(1) : count_q - CW'(1);
		end
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// request, pointer and result payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
		end
		if (cmd.eval) begin
			status_q <= status_d;
			slot_q   <= slot_e[AW-1:0];
			dst_q    <= is_ins ? AW'(count_q) : slot_e[AW-1:0];
		end
		if (cmd.take_cap) begin
			taken_q <= rdata_q;
		end
		if (cmd.shift_wr) begin
			dst_q <= is_ins ? dst_q - AW'(1) : dst_q + AW'(1);
		end
		if (cmd.finish) begin
			rsp_q.status      <= status_q;
			rsp_q.data_out    <= (ok && !is_ins) ? taken_q : '0;
			rsp_q.entry_count <= CNT_OUT_W'(count_d);
		end
	end

	// control state: entry count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/positional_list_engine.sv]
// Positional list engine: a bounded ordered list of up to DEPTH bytes with
// insert-before-position and remove-before-position requests, one result item
// per request item. An item that fails its check goes straight to the result
// load; otherwise n entries move, where n is at most DEPTH-1, and a remove
// first reads the removed byte. The single-port entry memory moves one entry
// per read and write pair. A new item is taken while the previous result
// still waits in the output register.
// Depends on ple_pkg, ple_ctrl and ple_dpath.
module positional_list_engine import ple_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	ple_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

[tb/positional_list_engine_tb.sv]
// Testbench for positional_list_engine: directed and random insert/remove items,
// with a class-based scoreboard that predicts every result and checks it in order.
// Depends on ple_pkg and the positional_list_engine RTL.
module positional_list_engine_tb;
	import ple_pkg::*;

	localparam int DEPTH = DEPTH_DEFAULT;

	// List predictor and expected-result queue
	class list_scoreboard;
		logic [DATA_W-1:0] slots [DEPTH];
		int unsigned       count;
		rsp_t              pending [$];
		int                errors;

		function new();
			count  = 0;
			errors = 0;
			foreach (slots[i]) slots[i] = '0;
		endfunction

		// work out the result of an accepted item and update the list
		function void note_request(req_t r);
			rsp_t e;
			int   pos;
			int   slot;
			e   = '0;
			pos = int'(r.position);
			if (r.req_type == REQ_INSERT) begin
				if (pos < 1 || pos > int'(count) + 1) begin
					e.status = STAT_BAD_POS;
				end else if (count >= DEPTH) begin
					e.status = STAT_FULL;
				end else begin
					for (int i = int'(count); i > pos - 1; i--) slots[i] = slots[i-1];
					slots[pos-1] = r.data_in;
					count++;
					e.status = STAT_OK;
				end
			end else begin
				if (count == 0) begin
					e.status = STAT_EMPTY;
				end else if (pos < 1 || pos > int'(count) + 1) begin
					e.status = STAT_BAD_POS;
				end else begin
					// positions 1 and 2 both take the head
					slot = (pos <= 2) ? 0 : pos - 2;
					e.data_out = slots[slot];
					for (int i = slot; i + 1 < int'(count); i++) slots[i] = slots[i+1];
					count--;
					e.status = STAT_OK;
				end
			end
			e.entry_count = CNT_OUT_W'(count);
			pending.push_back(e);
		endfunction

		// compare an accepted result with the oldest expectation
		function void check_result(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected: status %0d data_out %0d entry_count %0d",
					a.status, a.data_out, a.entry_count);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, a.status);
				errors++;
			end
			if (a.data_out !== e.data_out) begin
				$error("data_out: expected %0d, actual %0d", e.data_out, a.data_out);
				errors++;
			end
			if (a.entry_count !== e.entry_count) begin
				$error("entry_count: expected %0d, actual %0d", e.entry_count, a.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	list_scoreboard sb;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles_req;
	bit filling;

	positional_list_engine #(.DEPTH(DEPTH)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// offer one item, with an optional idle gap first; valid stays high if the next
	// item follows at once
	task automatic send_item(input req_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic send_op(input logic kind, input int pos, input int data);
		req_t r;
		r.req_type = kind;
		r.position = POS_W'(pos);
		r.data_in  = DATA_W'(data);
		send_item(r);
	endtask

	// random item: mostly legal positions, drifting between filling and draining
	function automatic req_t next_random_request();
		req_t        r;
		int unsigned cnt;
		bit          with_bias;
		cnt = sb.count;
		if (cnt >= DEPTH)
			filling = 1'b0;
		else if (cnt == 0)
			filling = 1'b1;
		else if ($urandom_range(99) < 4)
			filling = !filling;
		with_bias  = ($urandom_range(99) < 75);
		r.req_type = (with_bias == filling) ? REQ_INSERT : REQ_REMOVE;
		r.data_in  = DATA_W'($urandom_range(255));
		if ($urandom_range(99) < 10)
			r.position = POS_W'($urandom_range(31));
		else
			r.position = POS_W'($urandom_range(cnt + 1, 1));
		return r;
	endfunction

	task automatic run_phase(input int n, input int s_idle, input int r_stall);
		send_idle_pct  = s_idle;
		recv_stall_pct = r_stall;
		repeat (n) send_item(next_random_request());
	endtask

	// result side: check accepted items, drive random stall and long hold-offs
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) sb.check_result(rsp);
			if (hold_cycles_req > 0) begin
				hold_left       = hold_cycles_req;
				hold_cycles_req = 0;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// stimulus and end of run
	initial begin
		sb              = new();
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		req             = '0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_cycles_req = 0;
		filling         = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list and bad positions
		send_op(REQ_REMOVE, 0, 8'h3C);
		send_op(REQ_INSERT, 0, 8'h11);
		send_op(REQ_INSERT, 2, 8'h22);
		// head, front and middle inserts, data extremes
		send_op(REQ_INSERT, 1, 8'h00);
		send_op(REQ_INSERT, 1, 8'hFF);
		send_op(REQ_INSERT, 2, 8'h5A);
		// remove: bad positions, head via 2, tail via count+1, head via 1
		send_op(REQ_REMOVE, 0, 0);
		send_op(REQ_REMOVE, 5, 0);
		send_op(REQ_REMOVE, 2, 0);
		send_op(REQ_REMOVE, 3, 0);
		send_op(REQ_REMOVE, 1, 0);
		// fill up, then insert into the full list at a legal and an illegal position
		while (sb.count < DEPTH)
			send_op(REQ_INSERT, $urandom_range(sb.count + 1, 1), $urandom_range(255));
		send_op(REQ_INSERT, DEPTH + 1, 8'hA5);
		send_op(REQ_INSERT, 31, 8'h96);

		// random part
		filling = 1'b0;
		run_phase(200, 0, 0);
		run_phase(180, 68, 0);
		run_phase(180, 0, 68);
		run_phase(180, 20, 20);
		// long receiver hold-off while the sender keeps offering
		hold_cycles_req = 400;
		run_phase(100, 0, 0);
		run_phase(110, 10, 10);

		req_valid      <= 1'b0;
		recv_stall_pct = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// timeout
	initial begin
		#1000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[positional_list_engine.f]
rtl/ple_pkg.sv
rtl/ple_ctrl.sv
rtl/ple_dpath.sv
rtl/positional_list_engine.sv
tb/positional_list_engine_tb.sv
